// File: rtl/diff_drive_incremental_pid_assert.svh
// Assertion macros used by the top-level RTL of the wheel speed controller.
`ifndef DIFF_DRIVE_INCREMENTAL_PID_ASSERT_SVH
`define DIFF_DRIVE_INCREMENTAL_PID_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define DDPID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ddpid assertion failed");

// The consequent holds in the cycle after the antecedent.
`define DDPID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ddpid assertion failed");

`endif

// File: rtl/ddpid_pkg.sv
package ddpid_pkg;

  localparam int unsigned CfgAw = 5;
  localparam int unsigned DivNumW = 49;
  localparam int unsigned DivCntW = 6;

  localparam logic signed [65:0] DutyLimit = 66'sd6553600;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DERIV_GAIN   = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_RECIP_RADIUS = 3'd3,
    REG_WHEEL_SEP    = 3'd4,
    REG_MAX_INTERVAL = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_KIN,
    T_LANES,
    T_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    K_IDLE,
    K_P,
    K_WS,
    K_WSSAT,
    K_Q,
    K_SUM,
    K_ERR,
    K_DONE
  } kin_state_e;

  typedef enum logic [3:0] {
    L_IDLE,
    L_INTEG,
    L_PROP,
    L_IHI,
    L_ILO,
    L_DWAIT,
    L_DERIV,
    L_DACC,
    L_FINISH
  } lane_state_e;

  typedef struct packed {
    logic signed [31:0] prop;
    logic signed [31:0] deriv;
    logic signed [31:0] integ;
  } gains_t;

  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (x < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
    if (x > 66'sd140737488355327) begin
      return 48'sh7FFF_FFFF_FFFF;
    end
    if (x < -66'sd140737488355328) begin
      return 48'sh8000_0000_0000;
    end
    return x[47:0];
  endfunction

endpackage

// File: rtl/diff_drive_incremental_pid.sv
// Differential-drive wheel speed controller with an incremental PID per wheel. A word is
// accepted only while no earlier word is in progress; a finished result may still wait at
// the output. A normal word passes the shared kinematics multiplier, then the two wheel
// lanes run side by side, their length set by the 49-step restoring divider that forms
// the error rate when the elapsed time is nonzero. A timed-out word goes straight to the
// output and clears the lane integrators and previous errors. Gains and geometry must be
// written through the APB port only while idle; the block itself does not enforce this.
`include "diff_drive_incremental_pid_assert.svh"

module diff_drive_incremental_pid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddpid_pkg::CfgAw-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          linear_velocity_i,
  input  logic signed [31:0]          angular_velocity_i,
  input  logic signed [31:0]          measured_right_i,
  input  logic signed [31:0]          measured_left_i,
  input  logic        [23:0]          elapsed_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic        [6:0]           duty_right_o,
  output logic                        reverse_right_o,
  output logic        [6:0]           duty_left_o,
  output logic                        reverse_left_o,
  output logic                        timed_out_o
);

  ddpid_pkg::top_state_e state_q, state_d;
  ddpid_pkg::reg_idx_e   reg_idx;
  ddpid_pkg::gains_t     gains_q;
  ddpid_pkg::lane_ctrl_t lane_ctrl;

  logic [31:0] rr_q, sep_q;
  logic [23:0] max_int_q;

  logic signed [31:0] lin_q, ang_q, mr_q, ml_q;
  logic        [23:0] dt_q;
  logic               to_q;
  logic               kin_go_q;
  logic               r_done_q, l_done_q;

  logic        accept, cfg_wr, timeout_now, out_load;
  logic        kin_done;
  logic signed [31:0] err_r, err_l;
  logic        lr_done, ll_done, lr_busy, ll_busy;
  logic signed [23:0] acc_r, acc_l;
  logic        [23:0] mag_r, mag_l;

  logic        out_valid_q;
  logic [6:0]  duty_r_q, duty_l_q;
  logic        rev_r_q, rev_l_q, to_out_q;

  assign pready      = 1'b1;
  assign cfg_wr      = psel & penable & pwrite;
  assign reg_idx     = ddpid_pkg::reg_idx_e'(paddr[4:2]);
  assign accept      = in_valid_i & ~in_stall_o;
  assign timeout_now = elapsed_time_i > max_int_q;
  assign in_stall_o  = (state_q != ddpid_pkg::T_IDLE);

  always_comb begin
    case (reg_idx)
      ddpid_pkg::REG_PROP_GAIN:    prdata = gains_q.prop;
      ddpid_pkg::REG_DERIV_GAIN:   prdata = gains_q.deriv;
      ddpid_pkg::REG_INTEG_GAIN:   prdata = gains_q.integ;
      ddpid_pkg::REG_RECIP_RADIUS: prdata = rr_q;
      ddpid_pkg::REG_WHEEL_SEP:    prdata = sep_q;
      ddpid_pkg::REG_MAX_INTERVAL: prdata = {8'b0, max_int_q};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop  <= 32'sd655;
      gains_q.deriv <= 32'sd655;
      gains_q.integ <= 32'sd655;
      rr_q          <= 32'd2978909;
      sep_q         <= 32'd6357;
      max_int_q     <= 24'd65536;
    end else if (cfg_wr) begin
      case (reg_idx)
        ddpid_pkg::REG_PROP_GAIN:    gains_q.prop  <= pwdata;
        ddpid_pkg::REG_DERIV_GAIN:   gains_q.deriv <= pwdata;
        ddpid_pkg::REG_INTEG_GAIN:   gains_q.integ <= pwdata;
        ddpid_pkg::REG_RECIP_RADIUS: rr_q          <= pwdata;
        ddpid_pkg::REG_WHEEL_SEP:    sep_q         <= pwdata;
        ddpid_pkg::REG_MAX_INTERVAL: max_int_q     <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ddpid_pkg::T_IDLE: begin
        if (accept) begin
          state_d = timeout_now ? ddpid_pkg::T_OUT : ddpid_pkg::T_KIN;
        end
      end
      ddpid_pkg::T_KIN:   if (kin_done) state_d = ddpid_pkg::T_LANES;
      ddpid_pkg::T_LANES: if (r_done_q && l_done_q) state_d = ddpid_pkg::T_OUT;
      ddpid_pkg::T_OUT:   if (!out_valid_q || !out_stall_i) state_d = ddpid_pkg::T_IDLE;
      default:            state_d = ddpid_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    lane_ctrl.start = kin_done;
    lane_ctrl.clear = (state_q == ddpid_pkg::T_IDLE) & accept & timeout_now;
    out_load        = (state_q == ddpid_pkg::T_OUT) & (~out_valid_q | ~out_stall_i);
  end

  ddpid_kin u_kin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (kin_go_q),
    .lin_i    (lin_q),
    .ang_i    (ang_q),
    .meas_r_i (mr_q),
    .meas_l_i (ml_q),
    .rr_i     (rr_q),
    .sep_i    (sep_q),
    .done_o   (kin_done),
    .err_r_o  (err_r),
    .err_l_o  (err_l)
  );

  ddpid_lane u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .err_i      (err_r),
    .dt_i       (dt_q),
    .gains_i    (gains_q),
    .done_o     (lr_done),
    .busy_o     (lr_busy),
    .duty_acc_o (acc_r)
  );

  ddpid_lane u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .err_i      (err_l),
    .dt_i       (dt_q),
    .gains_i    (gains_q),
    .done_o     (ll_done),
    .busy_o     (ll_busy),
    .duty_acc_o (acc_l)
  );

  assign mag_r = acc_r[23] ? -acc_r : acc_r;
  assign mag_l = acc_l[23] ? -acc_l : acc_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddpid_pkg::T_IDLE;
      kin_go_q    <= 1'b0;
      r_done_q    <= 1'b0;
      l_done_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      kin_go_q <= accept & ~timeout_now;
      if (kin_done) begin
        r_done_q <= 1'b0;
        l_done_q <= 1'b0;
      end else begin
        r_done_q <= r_done_q | lr_done;
        l_done_q <= l_done_q | ll_done;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lin_q <= linear_velocity_i;
      ang_q <= angular_velocity_i;
      mr_q  <= measured_right_i;
      ml_q  <= measured_left_i;
      dt_q  <= elapsed_time_i;
      to_q  <= timeout_now;
    end
    if (out_load) begin
      duty_r_q <= mag_r[22:16];
      rev_r_q  <= acc_r[23];
      duty_l_q <= mag_l[22:16];
      rev_l_q  <= acc_l[23];
      to_out_q <= to_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign duty_right_o    = duty_r_q;
  assign reverse_right_o = rev_r_q;
  assign duty_left_o     = duty_l_q;
  assign reverse_left_o  = rev_l_q;
  assign timed_out_o     = to_out_q;

  `DDPID_ASSERT_NXT(a_accept_busy, accept, in_stall_o)
  `DDPID_ASSERT_IMP(a_idle_lanes, state_q == ddpid_pkg::T_IDLE, !lr_busy && !ll_busy)
  `DDPID_ASSERT_IMP(a_kin_in_kin, kin_done, state_q == ddpid_pkg::T_KIN)
  `DDPID_ASSERT_IMP(a_duty_range, out_valid_o, duty_right_o <= 7'd100 && duty_left_o <= 7'd100)

endmodule

// File: rtl/ddpid_div.sv
module ddpid_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [ddpid_pkg::DivNumW-1:0]  num_i,
  input  logic        [23:0]                    den_i,
  output logic                                  done_o,
  output logic signed [31:0]                    quot_o
);

  logic                                busy_q, busy_d;
  logic                                fin_q, fin_d;
  logic [ddpid_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [ddpid_pkg::DivNumW-1:0]       mag_q, mag_d;
  logic [23:0]                         rem_q, rem_d;
  logic [23:0]                         den_q, den_d;
  logic                                neg_q, neg_d;
  logic signed [31:0]                  quot_q, quot_d;
  logic [24:0]                         trial;
  logic [24:0]                         diff;

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    quot_d = quot_q;
    trial  = {rem_q, mag_q[ddpid_pkg::DivNumW-1]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ddpid_pkg::DivCntW'(ddpid_pkg::DivNumW);
      neg_d  = num_i[ddpid_pkg::DivNumW-1];
      mag_d  = num_i[ddpid_pkg::DivNumW-1] ? -num_i : num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[23:0];
        mag_d = {mag_q[ddpid_pkg::DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial[23:0];
        mag_d = {mag_q[ddpid_pkg::DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ddpid_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      if (neg_q) begin
        if (mag_q > ddpid_pkg::DivNumW'(64'd2147483648)) begin
          quot_d = 32'sh8000_0000;
        end else begin
          quot_d = -$signed(mag_q[31:0]);
        end
      end else begin
        if (mag_q > ddpid_pkg::DivNumW'(64'd2147483647)) begin
          quot_d = 32'sh7FFF_FFFF;
        end else begin
          quot_d = $signed(mag_q[31:0]);
        end
      end
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= fin_q & ~start_i;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/ddpid_kin.sv
module ddpid_kin (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] lin_i,
  input  logic signed [31:0] ang_i,
  input  logic signed [31:0] meas_r_i,
  input  logic signed [31:0] meas_l_i,
  input  logic        [31:0] rr_i,
  input  logic        [31:0] sep_i,
  output logic               done_o,
  output logic signed [31:0] err_r_o,
  output logic signed [31:0] err_l_o
);

  ddpid_pkg::kin_state_e state_q, state_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] prod_q, prod_d;
  logic signed [65:0] p_q, p_d;
  logic signed [31:0] ws_q, ws_d;
  logic signed [31:0] tr_q, tr_d;
  logic signed [31:0] tl_q, tl_d;
  logic signed [31:0] er_q, er_d;
  logic signed [31:0] el_q, el_d;
  logic signed [65:0] q_full, s_full, tr_full, tl_full;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ddpid_pkg::K_IDLE:  if (start_i) state_d = ddpid_pkg::K_P;
      ddpid_pkg::K_P:     state_d = ddpid_pkg::K_WS;
      ddpid_pkg::K_WS:    state_d = ddpid_pkg::K_WSSAT;
      ddpid_pkg::K_WSSAT: state_d = ddpid_pkg::K_Q;
      ddpid_pkg::K_Q:     state_d = ddpid_pkg::K_SUM;
      ddpid_pkg::K_SUM:   state_d = ddpid_pkg::K_ERR;
      ddpid_pkg::K_ERR:   state_d = ddpid_pkg::K_DONE;
      ddpid_pkg::K_DONE:  state_d = ddpid_pkg::K_IDLE;
      default:            state_d = ddpid_pkg::K_IDLE;
    endcase
  end

  always_comb begin
    mul_a   = {lin_i[31], lin_i};
    mul_b   = $signed({1'b0, rr_i});
    prod_d  = prod_q;
    p_d     = p_q;
    ws_d    = ws_q;
    tr_d    = tr_q;
    tl_d    = tl_q;
    er_d    = er_q;
    el_d    = el_q;
    q_full  = prod_q >>> 16;
    s_full  = (p_q <<< 1) + q_full;
    tr_full = s_full >>> 1;
    tl_full = (p_q <<< 1) - tr_full;
    case (state_q)
      ddpid_pkg::K_P: begin
        prod_d = mul_p;
      end
      ddpid_pkg::K_WS: begin
        p_d    = prod_q >>> 16;
        mul_a  = {ang_i[31], ang_i};
        mul_b  = $signed({1'b0, sep_i});
        prod_d = mul_p;
      end
      ddpid_pkg::K_WSSAT: begin
        ws_d = ddpid_pkg::sat32(prod_q >>> 16);
      end
      ddpid_pkg::K_Q: begin
        mul_a  = {ws_q[31], ws_q};
        prod_d = mul_p;
      end
      ddpid_pkg::K_SUM: begin
        tr_d = ddpid_pkg::sat32(tr_full);
        tl_d = ddpid_pkg::sat32(tl_full);
      end
      ddpid_pkg::K_ERR: begin
        er_d = ddpid_pkg::sat32(66'(tr_q) - 66'(meas_r_i));
        el_d = ddpid_pkg::sat32(66'(tl_q) - 66'(meas_l_i));
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddpid_pkg::K_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    p_q    <= p_d;
    ws_q   <= ws_d;
    tr_q   <= tr_d;
    tl_q   <= tl_d;
    er_q   <= er_d;
    el_q   <= el_d;
  end

  assign done_o  = (state_q == ddpid_pkg::K_DONE);
  assign err_r_o = er_q;
  assign err_l_o = el_q;

endmodule

// File: rtl/ddpid_lane.sv
module ddpid_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddpid_pkg::lane_ctrl_t ctrl_i,
  input  logic signed [31:0]    err_i,
  input  logic        [23:0]    dt_i,
  input  ddpid_pkg::gains_t     gains_i,
  output logic                  done_o,
  output logic                  busy_o,
  output logic signed [23:0]    duty_acc_o
);

  ddpid_pkg::lane_state_e state_q, state_d;
  logic signed [47:0] integ_q, integ_d;
  logic signed [31:0] prev_q, prev_d;
  logic signed [23:0] acc_q, acc_d;
  logic signed [65:0] sum_q, sum_d;
  logic signed [65:0] prod_q, prod_d;
  logic signed [31:0] rate_q, rate_d;
  logic               rate_vld_q, rate_vld_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] acc_sum;
  logic signed [32:0] err_diff;
  logic signed [ddpid_pkg::DivNumW-1:0] div_num;
  logic               div_done;
  logic signed [31:0] div_quot;

  assign err_diff = 33'(err_i) - 33'(prev_q);
  assign div_num  = {err_diff, 16'b0};

  ddpid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.start),
    .num_i   (div_num),
    .den_i   (dt_i),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ddpid_pkg::L_IDLE:   if (ctrl_i.start) state_d = ddpid_pkg::L_INTEG;
      ddpid_pkg::L_INTEG:  state_d = ddpid_pkg::L_PROP;
      ddpid_pkg::L_PROP:   state_d = ddpid_pkg::L_IHI;
      ddpid_pkg::L_IHI:    state_d = ddpid_pkg::L_ILO;
      ddpid_pkg::L_ILO:    state_d = ddpid_pkg::L_DWAIT;
      ddpid_pkg::L_DWAIT: begin
        if (dt_i == '0) begin
          state_d = ddpid_pkg::L_FINISH;
        end else if (rate_vld_q) begin
          state_d = ddpid_pkg::L_DERIV;
        end
      end
      ddpid_pkg::L_DERIV:  state_d = ddpid_pkg::L_DACC;
      ddpid_pkg::L_DACC:   state_d = ddpid_pkg::L_FINISH;
      ddpid_pkg::L_FINISH: state_d = ddpid_pkg::L_IDLE;
      default:             state_d = ddpid_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    mul_a      = {err_i[31], err_i};
    mul_b      = $signed({9'b0, dt_i});
    integ_d    = integ_q;
    prev_d     = prev_q;
    acc_d      = acc_q;
    sum_d      = sum_q;
    prod_d     = prod_q;
    rate_d     = rate_q;
    rate_vld_d = rate_vld_q;
    acc_sum    = 66'(acc_q) + sum_q;
    if (ctrl_i.start) begin
      rate_vld_d = 1'b0;
    end else if (div_done) begin
      rate_d     = div_quot;
      rate_vld_d = 1'b1;
    end
    case (state_q)
      ddpid_pkg::L_IDLE: begin
        if (ctrl_i.clear) begin
          integ_d = '0;
          prev_d  = '0;
        end
      end
      ddpid_pkg::L_INTEG: begin
        prod_d = mul_p;
      end
      ddpid_pkg::L_PROP: begin
        integ_d = ddpid_pkg::sat48(66'(integ_q) + (prod_q >>> 16));
        mul_a   = {gains_i.prop[31], gains_i.prop};
        mul_b   = {err_i[31], err_i};
        prod_d  = mul_p;
      end
      ddpid_pkg::L_IHI: begin
        sum_d  = prod_q >>> 16;
        mul_a  = {gains_i.integ[31], gains_i.integ};
        mul_b  = {integ_q[47], integ_q[47:16]};
        prod_d = mul_p;
      end
      ddpid_pkg::L_ILO: begin
        sum_d  = sum_q + prod_q;
        mul_a  = {gains_i.integ[31], gains_i.integ};
        mul_b  = $signed({17'b0, integ_q[15:0]});
        prod_d = mul_p;
      end
      ddpid_pkg::L_DWAIT: begin
        sum_d  = sum_q + (prod_q >>> 16);
        prod_d = '0;
      end
      ddpid_pkg::L_DERIV: begin
        mul_a  = {gains_i.deriv[31], gains_i.deriv};
        mul_b  = {rate_q[31], rate_q};
        prod_d = mul_p;
      end
      ddpid_pkg::L_DACC: begin
        sum_d = sum_q + (prod_q >>> 16);
      end
      ddpid_pkg::L_FINISH: begin
        prev_d = err_i;
        if (acc_sum > ddpid_pkg::DutyLimit) begin
          acc_d = ddpid_pkg::DutyLimit[23:0];
        end else if (acc_sum < -ddpid_pkg::DutyLimit) begin
          acc_d = 24'(-ddpid_pkg::DutyLimit);
        end else begin
          acc_d = acc_sum[23:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ddpid_pkg::L_IDLE;
      integ_q    <= '0;
      prev_q     <= '0;
      acc_q      <= '0;
      rate_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      integ_q    <= integ_d;
      prev_q     <= prev_d;
      acc_q      <= acc_d;
      rate_vld_q <= rate_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    prod_q <= prod_d;
    rate_q <= rate_d;
  end

  assign done_o     = (state_q == ddpid_pkg::L_FINISH);
  assign busy_o     = (state_q != ddpid_pkg::L_IDLE);
  assign duty_acc_o = acc_q;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ddpid_pkg::CfgAw-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] linear_velocity_i = '0, angular_velocity_i = '0;
  logic signed [31:0] measured_right_i = '0, measured_left_i = '0;
  logic [23:0] elapsed_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [6:0] duty_right_o, duty_left_o;
  logic reverse_right_o, reverse_left_o, timed_out_o;

  diff_drive_incremental_pid uut (.*);

  typedef struct packed {
    logic [6:0] duty_r;
    logic       rev_r;
    logic [6:0] duty_l;
    logic       rev_l;
    logic       tmo;
  } duty_word_t;

  duty_word_t duty_queue[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned hold_cycles = 0;

  longint kp, kd, ki, rr, sep, tmax;
  longint integ_r, integ_l, last_r, last_l, acc_r, acc_l;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam longint S48Max = 64'sd140737488355327;
  localparam longint S48Min = -64'sd140737488355328;
  localparam longint DutyMax = 64'sd6553600;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint fsh(longint x);
    return x >>> 16;
  endfunction

  task automatic lane_update(input longint e, input longint dt, inout longint integ,
                             inout longint prev, inout longint acc);
    longint pt, dtm, it, hi, lo, rate;
    dtm = 0;
    integ = clamp(integ + fsh(e * dt), S48Min, S48Max);
    pt = fsh(kp * e);
    if (dt != 0) begin
      rate = clamp(((e - prev) * 65536) / dt, S32Min, S32Max);
      dtm = fsh(kd * rate);
    end
    hi = fsh(integ);
    lo = integ - hi * 65536;
    it = ki * hi + fsh(ki * lo);
    prev = e;
    acc = clamp(acc + pt + dtm + it, -DutyMax, DutyMax);
  endtask

  function automatic longint mag(longint a);
    return ((a < 0 ? -a : a) >>> 16) & 127;
  endfunction

  task automatic predict_duty(input longint lin, ang, mr, ml, dt);
    longint p, ws, q, trf, tlf, er, el;
    duty_word_t w;
    w.tmo = dt > tmax;
    if (w.tmo) begin
      integ_r = 0; integ_l = 0; last_r = 0; last_l = 0;
    end else begin
      p = fsh(lin * rr);
      ws = clamp(fsh(ang * sep), S32Min, S32Max);
      q = fsh(ws * rr);
      trf = (2 * p + q) >>> 1;
      tlf = 2 * p - trf;
      er = clamp(clamp(trf, S32Min, S32Max) - mr, S32Min, S32Max);
      el = clamp(clamp(tlf, S32Min, S32Max) - ml, S32Min, S32Max);
      lane_update(er, dt, integ_r, last_r, acc_r);
      lane_update(el, dt, integ_l, last_l, acc_l);
    end
    w.duty_r = 7'(mag(acc_r));
    w.rev_r = acc_r < 0;
    w.duty_l = 7'(mag(acc_l));
    w.rev_l = acc_l < 0;
    duty_queue.push_back(w);
  endtask

  task automatic write_reg(input ddpid_pkg::reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ddpid_pkg::CfgAw'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ddpid_pkg::REG_PROP_GAIN:    kp = longint'(signed'(val));
      ddpid_pkg::REG_DERIV_GAIN:   kd = longint'(signed'(val));
      ddpid_pkg::REG_INTEG_GAIN:   ki = longint'(signed'(val));
      ddpid_pkg::REG_RECIP_RADIUS: rr = longint'(val);
      ddpid_pkg::REG_WHEEL_SEP:    sep = longint'(val);
      default:                     tmax = longint'(val[23:0]);
    endcase
  endtask

  task automatic send_word(input logic [31:0] lin, ang, mr, ml, input logic [23:0] dt);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    linear_velocity_i <= lin; angular_velocity_i <= ang;
    measured_right_i <= mr; measured_left_i <= ml; elapsed_time_i <= dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_duty(longint'(signed'(lin)), longint'(signed'(ang)), longint'(signed'(mr)),
                 longint'(signed'(ml)), longint'(dt));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (duty_queue.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    duty_word_t got, exp_w;
    if (out_valid_o && !out_stall_i) begin
      got = {duty_right_o, reverse_right_o, duty_left_o, reverse_left_o, timed_out_o};
      if (duty_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp_w = duty_queue.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", exp_w, got);
        end
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(2000) - 1000;
      3: return ($urandom_range(200000) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    send_word(0, 0, 0, 0, 0);
    send_word(32'h0001_0000, 0, 0, 0, 24'h00_1000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 24'h01_0000);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h00_0001);
    send_word(32'h0000_8000, 32'hFFFF_0000, 32'h1234, 32'hFFFF_EDCC, 0);
    send_word(32'h0001_0000, 32'h0001_0000, 0, 0, 24'hFF_FFFF);
    send_word(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFD_0000, 24'h01_0001);
    send_word(32'h0002_0000, 0, 0, 0, 24'h00_0800);
    drain();
    write_reg(ddpid_pkg::REG_RECIP_RADIUS, 0);
    send_word(32'h0005_0000, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000, 24'h00_1000);
    drain();
  endtask

  task automatic test_random(input int unsigned n);
    logic [23:0] dt;
    repeat (n) begin
      case ($urandom_range(9))
        0: dt = 24'($urandom);
        1: dt = 0;
        2: dt = tmax[23:0] + 24'd1;
        default: dt = 24'($urandom_range(tmax > 0 ? tmax : 1));
      endcase
      send_word(pick32(), pick32(), pick32(), pick32(), dt);
    end
    drain();
  endtask

  task automatic test_settings;
    write_reg(ddpid_pkg::REG_PROP_GAIN, 32'h7FFF_FFFF);
    write_reg(ddpid_pkg::REG_DERIV_GAIN, 32'h8000_0000);
    write_reg(ddpid_pkg::REG_INTEG_GAIN, 32'h7FFF_FFFF);
    write_reg(ddpid_pkg::REG_RECIP_RADIUS, 32'hFFFF_FFFF);
    write_reg(ddpid_pkg::REG_WHEEL_SEP, 32'hFFFF_FFFF);
    write_reg(ddpid_pkg::REG_MAX_INTERVAL, 32'h00FF_FFFF);
    test_random(100);
    write_reg(ddpid_pkg::REG_PROP_GAIN, 32'h8000_0000);
    write_reg(ddpid_pkg::REG_DERIV_GAIN, 32'h7FFF_FFFF);
    write_reg(ddpid_pkg::REG_INTEG_GAIN, 32'h8000_0000);
    write_reg(ddpid_pkg::REG_RECIP_RADIUS, 1);
    write_reg(ddpid_pkg::REG_WHEEL_SEP, 0);
    write_reg(ddpid_pkg::REG_MAX_INTERVAL, 0);
    test_random(60);
    write_reg(ddpid_pkg::REG_PROP_GAIN, $urandom_range(20000));
    write_reg(ddpid_pkg::REG_DERIV_GAIN, $urandom_range(2000));
    write_reg(ddpid_pkg::REG_INTEG_GAIN, $urandom_range(2000));
    write_reg(ddpid_pkg::REG_RECIP_RADIUS, 32'd2978909);
    write_reg(ddpid_pkg::REG_WHEEL_SEP, 32'd30000);
    write_reg(ddpid_pkg::REG_MAX_INTERVAL, 32'h0001_0000);
    test_random(140);
  endtask

  task automatic test_backpressure;
    hold_cycles = 400;
    test_random(12);
  endtask

  initial begin
    kp = 655; kd = 655; ki = 655; rr = 2978909; sep = 6357; tmax = 65536;
    integ_r = 0; integ_l = 0; last_r = 0; last_l = 0; acc_r = 0; acc_l = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 14; recv_idle_pct = 52;
    test_directed();
    test_random(300);
    send_idle_pct = 52; recv_idle_pct = 14;
    test_settings();
    test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(480);
    if (mismatches == 0 && duty_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
